// ===== rtl/core/dual_reflective_wheel_odometer_macros.svh =====
// assertion macros for the dual reflective wheel odometer
// used by the top level only, no other dependencies
`ifndef DUAL_REFLECTIVE_WHEEL_ODOMETER_MACROS_SVH
`define DUAL_REFLECTIVE_WHEEL_ODOMETER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DRWO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("drwo same-cycle check failed");

// next-cycle implication, disabled during reset
`define DRWO_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("drwo next-cycle check failed");

`endif

// ===== rtl/core/drwo_pkg.sv =====
// shared types and constants for the dual reflective wheel odometer
// no dependencies
package drwo_pkg;

    localparam int SAMPLE_WIDTH    = 8;
    localparam int MODE_WIDTH      = 2;
    localparam int RESULT_WIDTH    = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [MODE_WIDTH-1:0]   MODE_HOLD    = 2'd0;
    localparam logic [MODE_WIDTH-1:0]   MODE_FORWARD = 2'd1;
    localparam logic [MODE_WIDTH-1:0]   MODE_REVERSE = 2'd2;

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_RESET = 8'hFF;
    localparam logic [SAMPLE_WIDTH-1:0] MARGIN_RESET = 8'd5;
    localparam int                      TOTAL_RESET  = 100;

    typedef struct packed {
        logic [MODE_WIDTH-1:0]   mode;
        logic [SAMPLE_WIDTH-1:0] left_sample;
        logic [SAMPLE_WIDTH-1:0] right_sample;
    } in_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] left_count;
        logic [RESULT_WIDTH-1:0] right_count;
    } out_t;

    // per-channel update control
    typedef struct packed {
        logic en;
        logic up;
    } chan_ctrl_t;

endpackage

// ===== rtl/core/drwo_channel.sv =====
// one wheel channel: previous sample, arm flag and edge count with hysteresis
// depends on drwo_pkg
module drwo_channel #(
    parameter int COUNT_WIDTH = drwo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  drwo_pkg::chan_ctrl_t              ctrl,
    input  logic [drwo_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic [drwo_pkg::SAMPLE_WIDTH-1:0] margin,
    output logic [COUNT_WIDTH-1:0]            count_next,
    output logic [COUNT_WIDTH-1:0]            count
);

    logic [drwo_pkg::SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic                              armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0]            total_reg, total_next;
    logic [drwo_pkg::SAMPLE_WIDTH:0]   threshold;
    logic                              fall;
    logic                              rise;

    // threshold kept one bit wider so it never wraps
    assign threshold = {1'b0, prev_reg} + {1'b0, margin};
    assign fall      = armed_reg && (sample < prev_reg);
    assign rise      = ({1'b0, sample} > threshold);

    always_comb begin
        prev_next  = prev_reg;
        armed_next = armed_reg;
        total_next = total_reg;
        if (ctrl.en) begin
            prev_next = sample;
            if (fall) begin
                armed_next = 1'b0;
                total_next = ctrl.up ? total_reg + COUNT_WIDTH'(1)
                                     : total_reg - COUNT_WIDTH'(1);
            end else if (!armed_reg && rise) begin
                armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= drwo_pkg::SAMPLE_RESET;
            armed_reg <= 1'b0;
            total_reg <= COUNT_WIDTH'(drwo_pkg::TOTAL_RESET);
        end else begin
            prev_reg  <= prev_next;
            armed_reg <= armed_next;
            total_reg <= total_next;
        end
    end

    assign count_next = total_next;
    assign count      = total_reg;

endmodule

// ===== rtl/core/dual_reflective_wheel_odometer.sv =====
// an accepted request is held in the input register, and its counts then in the result register
// throughput: one request per cycle while results are taken, set by the combinational compare and count per channel
// the input register and result register let a new request in while a result waits
// reset (aresetn, synchronous, active low): previous samples 0xff, channels disarmed,
// counts 100, rise margin 5, both channels empty
module dual_reflective_wheel_odometer #(
    parameter int COUNT_WIDTH = drwo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_we,
    input  logic [drwo_pkg::SAMPLE_WIDTH-1:0] cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  drwo_pkg::in_t                     s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output drwo_pkg::out_t                    m_data
);

`include "dual_reflective_wheel_odometer_macros.svh"

    // rise margin register
    logic [drwo_pkg::SAMPLE_WIDTH-1:0] rise_margin_reg;

    // input stage
    logic          in_valid_reg;
    drwo_pkg::in_t in_reg;

    // result stage
    logic           out_valid_reg;
    drwo_pkg::out_t out_reg, out_next;

    logic                 advance;      // input stage moves into the result stage
    logic                 out_free;     // result stage can take a new value
    logic                 fwd_rev;
    drwo_pkg::chan_ctrl_t ctrl;

    logic [COUNT_WIDTH-1:0] left_cnt_next, right_cnt_next;
    logic [COUNT_WIDTH-1:0] left_cnt, right_cnt;

    // handshake: result stage frees when empty or taken, input stage when it advances
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // mode three acts as hold
    assign fwd_rev = (in_reg.mode == drwo_pkg::MODE_FORWARD) ||
                     (in_reg.mode == drwo_pkg::MODE_REVERSE);
    assign ctrl.en = advance && fwd_rev;
    assign ctrl.up = (in_reg.mode == drwo_pkg::MODE_FORWARD);

    drwo_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .sample     (in_reg.left_sample),
        .margin     (rise_margin_reg),
        .count_next (left_cnt_next),
        .count      (left_cnt)
    );

    drwo_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .sample     (in_reg.right_sample),
        .margin     (rise_margin_reg),
        .count_next (right_cnt_next),
        .count      (right_cnt)
    );

    // result fields carry the low bits of the count, zero extended when narrower
    generate
        if (COUNT_WIDTH >= drwo_pkg::RESULT_WIDTH) begin : g_trunc
            assign out_next.left_count  = left_cnt_next[drwo_pkg::RESULT_WIDTH-1:0];
            assign out_next.right_count = right_cnt_next[drwo_pkg::RESULT_WIDTH-1:0];
        end else begin : g_ext
            assign out_next.left_count  =
                {{(drwo_pkg::RESULT_WIDTH-COUNT_WIDTH){1'b0}}, left_cnt_next};
            assign out_next.right_count =
                {{(drwo_pkg::RESULT_WIDTH-COUNT_WIDTH){1'b0}}, right_cnt_next};
        end
    endgenerate

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_margin_reg <= drwo_pkg::MARGIN_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                rise_margin_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // a request that advances always lands in the result stage
    `DRWO_ASSERT_NXT(a_adv_lands, aclk, aresetn, advance, out_valid_reg)

    // request side only stalls when both stages are full
    `DRWO_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg)

    // hold requests and stalled requests leave the counts alone
    `DRWO_ASSERT_NXT(a_hold_stable, aclk, aresetn, in_valid_reg && !ctrl.en,
        $stable(left_cnt) && $stable(right_cnt))

    // a count moves by at most one edge per request
    `DRWO_ASSERT_NXT(a_step_one, aclk, aresetn, in_valid_reg,
        (left_cnt == $past(left_cnt)) || (left_cnt == $past(left_cnt) + COUNT_WIDTH'(1)) ||
        (left_cnt == $past(left_cnt) - COUNT_WIDTH'(1)))

endmodule

// ===== test/dual_reflective_wheel_odometer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the dual reflective wheel odometer
// depends on drwo_pkg and the dual_reflective_wheel_odometer top level
module dual_reflective_wheel_odometer_test;

    // mode three is not named in the package and behaves like hold
    localparam logic [drwo_pkg::MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
    localparam int LATENCY       = 2;
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD_LEN = 80;

    // model of one wheel channel
    typedef struct packed {
        logic [drwo_pkg::SAMPLE_WIDTH-1:0]    last;
        logic                                 armed;
        logic [drwo_pkg::COUNT_WIDTH_DEF-1:0] count;
    } wheel_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   cfg_we = 1'b0;
    logic   [drwo_pkg::SAMPLE_WIDTH-1:0] cfg_wdata = '0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    drwo_pkg::in_t  s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    drwo_pkg::out_t m_data;

    // requests waiting for the driver, and count pairs waiting for the block
    drwo_pkg::in_t  pending_reqs[$];
    drwo_pkg::out_t expected_counts[$];

    // predictor state, margin is written only while the block is idle
    logic   [drwo_pkg::SAMPLE_WIDTH-1:0] margin_now = drwo_pkg::MARGIN_RESET;
    wheel_t left_wheel;
    wheel_t right_wheel;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    logic   req_fire = 1'b0;
    logic   long_hold_req = 1'b0;
    logic   long_hold_done = 1'b0;
    int     hold_left = 0;
    int     fail_count = 0;
    int     quiet_cycles = 0;

    dual_reflective_wheel_odometer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one channel step: a fall counts and disarms, a rise past the margin re-arms
    function automatic wheel_t next_wheel(wheel_t w, logic [drwo_pkg::SAMPLE_WIDTH-1:0] sample,
                                          logic up, logic [drwo_pkg::SAMPLE_WIDTH-1:0] margin);
        if (w.armed && sample < w.last) begin
            w.count = up ? w.count + 1'b1 : w.count - 1'b1;
            w.armed = 1'b0;
        end
        // sum is nine bits wide so it never wraps
        if (!w.armed && {1'b0, sample} > {1'b0, w.last} + {1'b0, margin}) begin
            w.armed = 1'b1;
        end
        w.last = sample;
        return w;
    endfunction

    function automatic wheel_t wheel_at_reset();
        wheel_t w;
        int     total;
        total   = drwo_pkg::TOTAL_RESET;
        w.last  = drwo_pkg::SAMPLE_RESET;
        w.armed = 1'b0;
        w.count = total[drwo_pkg::COUNT_WIDTH_DEF-1:0];
        return w;
    endfunction

    function automatic logic [drwo_pkg::MODE_WIDTH-1:0] random_mode();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        return pick[drwo_pkg::MODE_WIDTH-1:0];
    endfunction

    // driver: new request on the falling edge once the previous one was taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_fire) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_reqs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_ready        <= 1'b0;
            hold_left      <= LONG_HOLD_LEN;
            long_hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        drwo_pkg::out_t predicted;
        drwo_pkg::out_t want;
        logic up;
        req_fire <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            left_wheel  = wheel_at_reset();
            right_wheel = wheel_at_reset();
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.mode == drwo_pkg::MODE_FORWARD ||
                    s_data.mode == drwo_pkg::MODE_REVERSE) begin
                    up = (s_data.mode == drwo_pkg::MODE_FORWARD);
                    left_wheel  = next_wheel(left_wheel, s_data.left_sample, up, margin_now);
                    right_wheel = next_wheel(right_wheel, s_data.right_sample, up, margin_now);
                end
                predicted.left_count  = left_wheel.count[drwo_pkg::RESULT_WIDTH-1:0];
                predicted.right_count = right_wheel.count[drwo_pkg::RESULT_WIDTH-1:0];
                expected_counts.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t unexpected result: expected none, got left %0d right %0d",
                             $time, m_data.left_count, m_data.right_count);
                    fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (m_data.left_count !== want.left_count) begin
                        $display("%0t left_count mismatch: expected %0d, got %0d",
                                 $time, want.left_count, m_data.left_count);
                        fail_count++;
                    end
                    if (m_data.right_count !== want.right_count) begin
                        $display("%0t right_count mismatch: expected %0d, got %0d",
                                 $time, want.right_count, m_data.right_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves a request or result
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL dual_reflective_wheel_odometer");
                $finish;
            end
        end
    end

    task automatic push_req(logic [drwo_pkg::MODE_WIDTH-1:0] mode, int left, int right);
        drwo_pkg::in_t r;
        r.mode         = mode;
        r.left_sample  = left[drwo_pkg::SAMPLE_WIDTH-1:0];
        r.right_sample = right[drwo_pkg::SAMPLE_WIDTH-1:0];
        pending_reqs.push_back(r);
    endtask

    // troughs stay in the lower part, crests start above every trough plus the
    // margin, so each crest arms and each following trough falls below it
    function automatic int trough_sample();
        return $urandom_range(0, (254 - int'(margin_now)) / 2);
    endfunction

    function automatic int crest_floor();
        return (254 - int'(margin_now)) / 2 + int'(margin_now) + 1;
    endfunction

    // sawtooth: trough then crest on both wheels, so each crest arms and the
    // next trough counts; some requests are replaced by noise
    task automatic push_sawtooth(logic [drwo_pkg::MODE_WIDTH-1:0] mode, int pairs,
                                 int noise_pct);
        int lo_l;
        int lo_r;
        for (int i = 0; i < pairs; i++) begin
            if (margin_now == 8'd255) begin
                push_req(mode, $urandom_range(0, 255), $urandom_range(0, 255));
                push_req(mode, $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                lo_l = trough_sample();
                lo_r = trough_sample();
                push_req(mode, lo_l, lo_r);
                if ($urandom_range(0, 99) < noise_pct) begin
                    push_req(random_mode(), $urandom_range(0, 255), $urandom_range(0, 255));
                end else begin
                    push_req(mode, $urandom_range(crest_floor(), 255),
                             $urandom_range(crest_floor(), 255));
                end
            end
        end
    endtask

    // mostly forward and reverse bursts, some hold and fully random requests
    task automatic push_mixed(int count);
        int pick;
        int pairs;
        while (count > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                push_req(random_mode(), $urandom_range(0, 255), $urandom_range(0, 255));
                count -= 1;
            end else begin
                pairs = $urandom_range(1, 6);
                push_sawtooth((pick < 56) ? drwo_pkg::MODE_FORWARD : drwo_pkg::MODE_REVERSE,
                              pairs, 15);
                count -= 2 * pairs;
            end
        end
    endtask

    // block is idle once nothing is queued, offered or still owed
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_counts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_margin(int value);
        wait_drained();
        @(negedge aclk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value[drwo_pkg::SAMPLE_WIDTH-1:0];
        margin_now <= value[drwo_pkg::SAMPLE_WIDTH-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset margin of five, previous samples at full scale
        set_idling(0, 0);
        push_req(drwo_pkg::MODE_HOLD, 0, 0);          // hold leaves everything alone
        push_req(MODE_SPARE, 0, 255);                 // mode three also holds
        push_req(drwo_pkg::MODE_FORWARD, 0, 0);       // drop from full scale, not armed yet
        push_req(drwo_pkg::MODE_FORWARD, 255, 6);     // both rise past the margin and arm
        push_req(drwo_pkg::MODE_FORWARD, 0, 5);       // both fall and count up, no re-arm
        push_req(drwo_pkg::MODE_HOLD, 200, 200);      // hold keeps previous samples
        push_req(drwo_pkg::MODE_FORWARD, 5, 11);      // left rise equal to margin stays off
        push_req(drwo_pkg::MODE_REVERSE, 6, 10);      // right falls and counts down
        push_req(MODE_SPARE, 255, 255);
        push_req(drwo_pkg::MODE_REVERSE, 255, 255);   // both arm
        push_req(drwo_pkg::MODE_REVERSE, 254, 0);     // both count down
        push_req(drwo_pkg::MODE_FORWARD, 255, 255);   // previous plus margin past 255 must not wrap
        push_req(drwo_pkg::MODE_FORWARD, 0, 254);
        push_req(drwo_pkg::MODE_FORWARD, 255, 255);
        push_req(drwo_pkg::MODE_REVERSE, 255, 255);   // no fall on equal samples
        push_req(drwo_pkg::MODE_REVERSE, 170, 85);
        push_req(drwo_pkg::MODE_FORWARD, 85, 170);

        // zero margin: walk both counts down through zero, then back up
        // through all ones, with a long receiver hold at the start
        write_margin(0);
        long_hold_req <= 1'b1;
        push_sawtooth(drwo_pkg::MODE_REVERSE, 118, 3);
        push_sawtooth(drwo_pkg::MODE_FORWARD, 30, 3);

        // full-scale margin, nothing can arm, random requests with sender gaps
        write_margin(255);
        set_idling(61, 0);
        for (int i = 0; i < 100; i++) begin
            push_req(random_mode(), $urandom_range(0, 255), $urandom_range(0, 255));
        end

        write_margin($urandom_range(1, 60));
        set_idling(0, 61);
        push_mixed(130);

        write_margin($urandom_range(1, 254));
        set_idling(38, 38);
        push_mixed(130);

        write_margin(128);
        set_idling(0, 0);
        push_mixed(90);

        wait_drained();
        repeat (LATENCY + 8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS dual_reflective_wheel_odometer");
        end else begin
            $display("FAIL dual_reflective_wheel_odometer");
        end
        $finish;
    end

endmodule
